@@ rtl/sabs_pkg.sv @@
// ----------------------------------------------------------------------------
// sabs_pkg
// Shared widths, codes and types for the sorted-array binary search block.
// ----------------------------------------------------------------------------
package sabs_pkg;

  localparam int KEY_W   = 32;
  localparam int ADDR_W  = 10;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // result status codes
  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // store port strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

@@ rtl/sabs_if.sv @@
// ----------------------------------------------------------------------------
// sabs channel interfaces
// Valid/ready channels for requests, results and the entry count write.
// ----------------------------------------------------------------------------
interface sabs_in_if;
  import sabs_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ADDR_W-1:0]  load_address;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output req_type, output load_address,
                  output key_value, input ready);
  modport sink   (input valid, input req_type, input load_address,
                  input key_value, output ready);
endinterface

interface sabs_out_if;
  import sabs_pkg::*;

  logic               valid;
  logic               ready;
  logic               search_status;
  logic [INDEX_W-1:0] match_index;

  modport source (output valid, output search_status, output match_index,
                  input ready);
  modport sink   (input valid, input search_status, input match_index,
                  output ready);
endinterface

interface sabs_cfg_if;
  import sabs_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sabs_store.sv @@
// ----------------------------------------------------------------------------
// sabs_store
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sabs_store #(
  parameter int STORE_DEPTH = 1024,
  parameter int IDXW        = 10
) (
  input  logic                        clk,
  input  sabs_pkg::store_ctl_t        ctl,
  input  logic [IDXW-1:0]             wr_addr,
  input  logic [sabs_pkg::KEY_W-1:0]  wr_data,
  input  logic [IDXW-1:0]             rd_addr,
  output logic [sabs_pkg::KEY_W-1:0]  rd_data
);
  import sabs_pkg::*;

  logic [KEY_W-1:0] mem [STORE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sabs_seq.sv @@
// ----------------------------------------------------------------------------
// sabs_seq
// Search sequencer: one key compare per cycle narrows the low/high range.
// ----------------------------------------------------------------------------
module sabs_seq #(
  parameter int STORE_DEPTH = 1024,
  parameter int IDXW        = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sabs_in_if.sink                     in_chan,
  sabs_out_if.source                  out_chan,
  input  logic [IDXW:0]               count,
  output sabs_pkg::store_ctl_t        ctl,
  output logic [IDXW-1:0]             wr_addr,
  output logic [sabs_pkg::KEY_W-1:0]  wr_data,
  output logic [IDXW-1:0]             rd_addr,
  input  logic [sabs_pkg::KEY_W-1:0]  rd_data
);
  import sabs_pkg::*;

  localparam int EW = (IDXW > ADDR_W) ? IDXW : ADDR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_HOLD
  } state_t;

  state_t             st_r, st_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IDXW-1:0]    low_r, low_nxt;
  logic [IDXW-1:0]    high_r, high_nxt;
  logic [IDXW-1:0]    probe_r, probe_nxt;
  logic               res_status_r, res_status_nxt;
  logic [INDEX_W-1:0] res_index_r, res_index_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;

  logic               accept;
  logic               slot_free;
  logic               fin;
  logic               fin_status;
  logic [INDEX_W-1:0] fin_index;
  logic [IDXW-1:0]    high_init;
  logic [IDXW:0]      mid_sum;
  logic [EW-1:0]      addr_ext;
  logic [EW-1:0]      probe_ext;
  logic               key_lt;
  logic               key_eq;

  assign accept    = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign high_init = IDXW'(count - (IDXW+1)'(1));
  assign addr_ext  = EW'(in_chan.load_address);
  assign probe_ext = EW'(probe_r);
  assign key_lt    = $signed(rd_data) < $signed(key_r);
  assign key_eq    = rd_data == key_r;

  assign wr_addr = addr_ext[IDXW-1:0];
  assign wr_data = in_chan.key_value;

  always_comb begin
    st_nxt         = st_r;
    key_nxt        = key_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    probe_nxt      = probe_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    ctl            = '0;
    rd_addr        = probe_r;
    fin            = 1'b0;
    fin_status     = STATUS_NOT_FOUND;
    fin_index      = '0;
    mid_sum        = '0;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_chan.req_type == REQ_LOAD) begin
            ctl.wr_en = 32'(in_chan.load_address) < 32'(STORE_DEPTH);
          end else begin
            key_nxt = in_chan.key_value;
            if (count == '0) begin
              fin = 1'b1;
            end else begin
              low_nxt   = '0;
              high_nxt  = high_init;
              probe_nxt = high_init >> 1;
              rd_addr   = probe_nxt;
              ctl.rd_en = 1'b1;
              st_nxt    = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (key_eq) begin
          fin        = 1'b1;
          fin_status = STATUS_FOUND;
          fin_index  = probe_ext[INDEX_W-1:0];
        end else if (key_lt) begin
          if (probe_r >= high_r) begin
            fin = 1'b1;
          end else begin
            low_nxt = probe_r + IDXW'(1);
          end
        end else begin
          if (probe_r <= low_r) begin
            fin = 1'b1;
          end else begin
            high_nxt = probe_r - IDXW'(1);
          end
        end
        if (!fin) begin
          // next midpoint straight to the store read port
          mid_sum   = {1'b0, low_nxt} + {1'b0, high_nxt};
          probe_nxt = mid_sum[IDXW:1];
          rd_addr   = probe_nxt;
          ctl.rd_en = 1'b1;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      res_status_nxt = fin_status;
      res_index_nxt  = fin_index;
      if (slot_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_index_nxt  = fin_index;
        st_nxt         = ST_IDLE;
      end else begin
        st_nxt = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    probe_r      <= probe_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign in_chan.ready          = st_r == ST_IDLE;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.search_status = out_status_r;
  assign out_chan.match_index   = out_index_r;

  // search range never inverts while probing
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_PROBE |-> low_r <= high_r)
    else $error("search range inverted");

  // probe stays inside the live range
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_PROBE |-> (probe_r >= low_r) && (probe_r <= high_r))
    else $error("probe outside search range");

  // a held result only exists because the output slot is occupied
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_HOLD |-> out_valid_r)
    else $error("result held with free output slot");

  // store is never read and written in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_en && ctl.rd_en))
    else $error("store read and write collide");

endmodule

@@ rtl/sorted_array_binary_search.sv @@
// Load beat: no result; the block is ready again the next cycle.
// Search beat: accepted while idle, then one store probe per cycle, at most
//   floor(log2(entry_count)) + 1 probes (11 at a depth of 1024); the result
//   is registered with the final compare if the output slot is free.
// Reset clears the sequencer, the output slot and entry_count; store contents
//   stay undefined until loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
// sorted_array_binary_search
// Binary search over a loaded store of sorted signed keys.
// ----------------------------------------------------------------------------
module sorted_array_binary_search #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  sabs_in_if.sink     in_chan,
  sabs_out_if.source  out_chan,
  sabs_cfg_if.sink    cfg_chan
);
  import sabs_pkg::*;

  localparam int IDXW = $clog2(STORE_DEPTH);
  localparam int CW   = (IDXW + 1 > COUNT_W) ? IDXW + 1 : COUNT_W;

  logic [COUNT_W-1:0] entry_count_r;
  logic [CW-1:0]      count_ext;
  logic [CW-1:0]      count_clamp;
  store_ctl_t         ctl;
  logic [IDXW-1:0]    wr_addr;
  logic [KEY_W-1:0]   wr_data;
  logic [IDXW-1:0]    rd_addr;
  logic [KEY_W-1:0]   rd_data;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      entry_count_r <= cfg_chan.data;
    end
  end

  // counts beyond the store depth search the whole store
  assign count_ext   = CW'(entry_count_r);
  assign count_clamp = (count_ext > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : count_ext;

  sabs_seq #(
    .STORE_DEPTH (STORE_DEPTH),
    .IDXW        (IDXW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .count    (count_clamp[IDXW:0]),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  sabs_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .IDXW        (IDXW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
